// ===== sv/ffsa_pkg.sv =====
package ffsa_pkg;

    localparam int DATA_W = 16;

    localparam logic [DATA_W-1:0] RST_BASE = 16'd4096;
    localparam logic [DATA_W-1:0] RST_LEN  = 16'd32767;
    localparam logic [DATA_W-1:0] RST_END  = 16'd36863;
    localparam logic [DATA_W-1:0] SEG_NONE = 16'h0000;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [1:0] STATUS_OVERLAP = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_SIZE = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CARVE,
        CMD_REMOVE,
        CMD_MERGE_BOTH,
        CMD_MERGE_NEXT,
        CMD_MERGE_PREV,
        CMD_INSERT
    } cmd_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        cmd_op_t           op;
        logic              capture;
        logic              free_mode;
        logic              load_valid;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] seg;
    } cmd_t;

endpackage

// ===== sv/first_fit_segment_allocator.sv =====
// Flow: free and refused allocate pass from accept through search, decide and finish;
// successful allocate also passes through a sweep, waiting for the running maximum to
// ripple down the cell row.
// Items: one at a time; a new item is taken once the previous one finishes,
// even while its result waits in the output register.
// Reset: table holds one extent at segment 4096 of 32767 paragraphs, end at 36863.
// Every configuration write rebuilds the table.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int MAX_EXTENTS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [DATA_W-1:0] request_size,
    input  logic [DATA_W-1:0] block_segment,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] granted_segment,
    output logic [1:0]        status,
    output logic [DATA_W-1:0] largest_free
);

    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_EXTENTS);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] base_reg, size_reg, end_reg, largest_reg;
    logic              op_reg;
    logic [DATA_W-1:0] rsize_reg, rseg_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [DATA_W-1:0] j_start_reg, j_len_reg, p_start_reg, p_len_reg;
    logic              j_found_reg, j_valid_reg, j_at0_reg, full_reg;

    logic [DATA_W-1:0] res_granted_reg, res_largest_reg;
    logic [1:0]        res_status_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_granted_reg, out_largest_reg;
    logic [1:0]        out_status_reg;

    cmd_t cmd;

    logic [DATA_W-1:0] c_start [MAX_EXTENTS];
    logic [DATA_W-1:0] c_len   [MAX_EXTENTS];
    logic              c_valid [MAX_EXTENTS];
    logic [DATA_W-1:0] c_m     [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] c_first, c_prev, c_before;

    genvar g;
    generate
        for (g = 0; g < MAX_EXTENTS; g++)
        begin : g_cell
            ffsa_cell #(
                .FIRST(g == 0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_start ((g == 0) ? SEG_NONE : c_start[(g == 0) ? 0 : g - 1]),
                .left_len   ((g == 0) ? SEG_NONE : c_len[(g == 0) ? 0 : g - 1]),
                .left_valid ((g == 0) ? 1'b0 : c_valid[(g == 0) ? 0 : g - 1]),
                .right_start((g == MAX_EXTENTS - 1) ? SEG_NONE
                             : c_start[(g == MAX_EXTENTS - 1) ? g : g + 1]),
                .right_len  ((g == MAX_EXTENTS - 1) ? SEG_NONE
                             : c_len[(g == MAX_EXTENTS - 1) ? g : g + 1]),
                .right_valid((g == MAX_EXTENTS - 1) ? 1'b0
                             : c_valid[(g == MAX_EXTENTS - 1) ? g : g + 1]),
                .before_in  ((g == 0) ? 1'b0 : c_before[(g == 0) ? 0 : g - 1]),
                .before_out (c_before[g]),
                .first_right((g == MAX_EXTENTS - 1) ? !c_before[MAX_EXTENTS - 1]
                             : c_first[(g == MAX_EXTENTS - 1) ? g : g + 1]),
                .first_now  (c_first[g]),
                .prev_now   (c_prev[g]),
                .start      (c_start[g]),
                .len        (c_len[g]),
                .valid      (c_valid[g]),
                .m_in       ((g == 0) ? SEG_NONE : c_m[(g == 0) ? 0 : g - 1]),
                .m_out      (c_m[g])
            );
        end
    endgenerate

    logic [DATA_W-1:0] sel_j_start, sel_j_len, sel_p_start, sel_p_len;
    logic              sel_j_valid;

    always_comb
    begin
        sel_j_start = SEG_NONE;
        sel_j_len   = SEG_NONE;
        sel_p_start = SEG_NONE;
        sel_p_len   = SEG_NONE;
        sel_j_valid = 1'b0;
        for (int i = 0; i < MAX_EXTENTS; i++)
        begin
            sel_j_start = sel_j_start | (c_first[i] ? c_start[i] : SEG_NONE);
            sel_j_len   = sel_j_len   | (c_first[i] ? c_len[i] : SEG_NONE);
            sel_j_valid = sel_j_valid | (c_first[i] & c_valid[i]);
            sel_p_start = sel_p_start | (c_prev[i] ? c_start[i] : SEG_NONE);
            sel_p_len   = sel_p_len   | (c_prev[i] ? c_len[i] : SEG_NONE);
        end
    end

    // rebuild values for a configuration write
    logic [DATA_W-1:0] nb, ns, ld_len, ld_end, ld_largest;
    logic [DATA_W:0]   last_full;
    logic [DATA_W-1:0] last_clip;
    logic              ld_valid;

    always_comb
    begin
        nb         = (cfg_index == REG_HEAP_BASE) ? cfg_wdata : base_reg;
        ns         = (cfg_index == REG_HEAP_SIZE) ? cfg_wdata : size_reg;
        last_full  = {1'b0, nb} + {1'b0, ns} - {{DATA_W{1'b0}}, 1'b1};
        last_clip  = last_full[DATA_W] ? {DATA_W{1'b1}} : last_full[DATA_W-1:0];
        ld_valid   = (ns >= 16'd2) && (last_clip > nb);
        ld_end     = (ns < 16'd2) ? nb : last_clip;
        ld_len     = last_clip - nb;
        ld_largest = ld_valid ? ld_len : SEG_NONE;
    end

    // decision on the captured search results
    logic [DATA_W:0]   end17, prev_end17, succ17;
    logic              next_merge, prev_merge;
    logic [DATA_W-1:0] result_len;
    cmd_op_t           dec_op;
    logic [1:0]        dec_status;
    logic [DATA_W-1:0] dec_granted, dec_largest;
    logic              dec_sweep;

    always_comb
    begin
        end17       = {1'b0, rseg_reg} + {1'b0, rsize_reg};
        prev_end17  = {1'b0, p_start_reg} + {1'b0, p_len_reg};
        succ17      = {1'b0, (j_found_reg && j_valid_reg) ? j_start_reg : end_reg};
        next_merge  = j_found_reg && j_valid_reg && (end17 == {1'b0, j_start_reg});
        prev_merge  = !j_at0_reg && (prev_end17 == {1'b0, rseg_reg});
        dec_op      = CMD_NONE;
        dec_status  = STATUS_OK;
        dec_granted = SEG_NONE;
        dec_largest = largest_reg;
        dec_sweep   = 1'b0;
        result_len  = rsize_reg;
        if (op_reg == OP_ALLOC)
        begin
            if (rsize_reg == SEG_NONE || rsize_reg > largest_reg || !j_found_reg)
                dec_status = STATUS_NO_FIT;
            else
            begin
                dec_granted = j_start_reg;
                dec_op      = (j_len_reg > rsize_reg) ? CMD_CARVE : CMD_REMOVE;
                dec_sweep   = 1'b1;
            end
        end
        else
        begin
            if (next_merge && prev_merge)
                result_len = p_len_reg + rsize_reg + j_len_reg;
            else if (next_merge)
                result_len = j_len_reg + rsize_reg;
            else if (prev_merge)
                result_len = p_len_reg + rsize_reg;
            if (end17 > succ17)
                dec_status = STATUS_OVERLAP;
            else if (!next_merge && !prev_merge && full_reg)
                dec_status = STATUS_FULL;
            else
            begin
                if (next_merge && prev_merge)
                    dec_op = CMD_MERGE_BOTH;
                else if (next_merge)
                    dec_op = CMD_MERGE_NEXT;
                else if (prev_merge)
                    dec_op = CMD_MERGE_PREV;
                else
                    dec_op = CMD_INSERT;
                if (result_len > largest_reg)
                    dec_largest = result_len;
            end
        end
    end

    logic finish_go;
    assign finish_go = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SEARCH;
            ST_SEARCH: state_next = ST_DECIDE;
            ST_DECIDE: state_next = dec_sweep ? ST_SWEEP : ST_FINISH;
            ST_SWEEP:  if (cnt_reg == CNT_LAST) state_next = ST_FINISH;
            ST_FINISH: if (finish_go) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op         = CMD_NONE;
        cmd.capture    = 1'b0;
        cmd.free_mode  = op_reg;
        cmd.load_valid = ld_valid;
        cmd.size       = rsize_reg;
        cmd.seg        = rseg_reg;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_SEARCH: cmd.capture = 1'b1;
            ST_DECIDE: cmd.op = dec_op;
            ST_SWEEP:  cmd.op = CMD_NONE;
            ST_FINISH: cmd.op = CMD_NONE;
            default:   cmd.op = CMD_NONE;
        endcase
        if (cfg_we)
        begin
            cmd.op   = CMD_LOAD;
            cmd.size = ld_len;
            cmd.seg  = nb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= RST_BASE;
            size_reg      <= 16'd32768;
            end_reg       <= RST_END;
            largest_reg   <= RST_LEN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                base_reg    <= nb;
                size_reg    <= ns;
                end_reg     <= ld_end;
                largest_reg <= ld_largest;
            end
            else if (state_reg == ST_DECIDE && !dec_sweep)
                largest_reg <= dec_largest;
            else if (state_reg == ST_SWEEP && cnt_reg == CNT_LAST)
                largest_reg <= c_m[MAX_EXTENTS-1];
            if (state_reg == ST_SWEEP)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (state_reg == ST_FINISH && finish_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg    <= operation;
            rsize_reg <= request_size;
            rseg_reg  <= block_segment;
        end
        if (state_reg == ST_SEARCH)
        begin
            j_found_reg <= c_before[MAX_EXTENTS-1];
            j_start_reg <= sel_j_start;
            j_len_reg   <= sel_j_len;
            j_valid_reg <= sel_j_valid;
            j_at0_reg   <= c_first[0];
            p_start_reg <= sel_p_start;
            p_len_reg   <= sel_p_len;
            full_reg    <= c_valid[MAX_EXTENTS-1];
        end
        if (state_reg == ST_DECIDE)
        begin
            res_granted_reg <= dec_granted;
            res_status_reg  <= dec_status;
            res_largest_reg <= dec_largest;
        end
        else if (state_reg == ST_SWEEP && cnt_reg == CNT_LAST)
            res_largest_reg <= c_m[MAX_EXTENTS-1];
        if (state_reg == ST_FINISH && finish_go)
        begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
            out_largest_reg <= res_largest_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_segment = out_granted_reg;
    assign status          = out_status_reg;
    assign largest_free    = out_largest_reg;

    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SEARCH))
        else $error("accepted item did not start a search");

    a_first_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> $onehot0(c_first))
        else $error("more than one first-hit cell");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && state_reg != ST_FINISH) |=> !out_valid)
        else $error("taken result was not retired");

    a_cmd_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != CMD_NONE) |-> (state_reg == ST_DECIDE || cfg_we))
        else $error("table update outside decide or rebuild");

endmodule

// ===== sv/ffsa_cell.sv =====
module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter bit FIRST = 1'b0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [DATA_W-1:0] left_start,
    input  logic [DATA_W-1:0] left_len,
    input  logic              left_valid,
    input  logic [DATA_W-1:0] right_start,
    input  logic [DATA_W-1:0] right_len,
    input  logic              right_valid,
    input  logic              before_in,
    output logic              before_out,
    input  logic              first_right,
    output logic              first_now,
    output logic              prev_now,
    output logic [DATA_W-1:0] start,
    output logic [DATA_W-1:0] len,
    output logic              valid,
    input  logic [DATA_W-1:0] m_in,
    output logic [DATA_W-1:0] m_out
);

    logic [DATA_W-1:0] start_reg, start_next;
    logic [DATA_W-1:0] len_reg, len_next;
    logic              valid_reg, valid_next;
    logic              is_j_reg, after_reg, is_prev_reg;
    logic [DATA_W-1:0] m_reg;
    logic              hit;

    assign hit = cmd.free_mode ? (!valid_reg || start_reg >= cmd.seg)
                               : (valid_reg && len_reg >= cmd.size);
    assign first_now  = hit && !before_in;
    assign before_out = before_in || hit;
    assign prev_now   = first_right;

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        valid_next = valid_reg;
        case (cmd.op)
            CMD_LOAD:
            begin
                if (FIRST)
                begin
                    start_next = cmd.load_valid ? cmd.seg : SEG_NONE;
                    len_next   = cmd.load_valid ? cmd.size : SEG_NONE;
                    valid_next = cmd.load_valid;
                end
                else
                begin
                    start_next = SEG_NONE;
                    len_next   = SEG_NONE;
                    valid_next = 1'b0;
                end
            end
            CMD_CARVE:
            begin
                if (is_j_reg)
                begin
                    start_next = start_reg + cmd.size;
                    len_next   = len_reg - cmd.size;
                end
            end
            CMD_REMOVE:
            begin
                if (is_j_reg || after_reg)
                begin
                    start_next = right_start;
                    len_next   = right_len;
                    valid_next = right_valid;
                end
            end
            CMD_MERGE_BOTH:
            begin
                if (is_prev_reg)
                    len_next = len_reg + cmd.size + right_len;
                if (is_j_reg || after_reg)
                begin
                    start_next = right_start;
                    len_next   = right_len;
                    valid_next = right_valid;
                end
            end
            CMD_MERGE_NEXT:
            begin
                if (is_j_reg)
                begin
                    start_next = cmd.seg;
                    len_next   = len_reg + cmd.size;
                end
            end
            CMD_MERGE_PREV:
            begin
                if (is_prev_reg)
                    len_next = len_reg + cmd.size;
            end
            CMD_INSERT:
            begin
                if (is_j_reg)
                begin
                    start_next = cmd.seg;
                    len_next   = cmd.size;
                    valid_next = 1'b1;
                end
                else if (after_reg)
                begin
                    start_next = left_start;
                    len_next   = left_len;
                    valid_next = left_valid;
                end
            end
            default:
            begin
                start_next = start_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= FIRST ? RST_BASE : SEG_NONE;
            len_reg     <= FIRST ? RST_LEN : SEG_NONE;
            valid_reg   <= FIRST;
            is_j_reg    <= 1'b0;
            after_reg   <= 1'b0;
            is_prev_reg <= 1'b0;
            m_reg       <= SEG_NONE;
        end
        else
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
            m_reg     <= (len_reg > m_in) ? len_reg : m_in;
            if (cmd.capture)
            begin
                is_j_reg    <= first_now;
                after_reg   <= before_in;
                is_prev_reg <= first_right;
            end
        end
    end

    assign start = start_reg;
    assign len   = len_reg;
    assign valid = valid_reg;
    assign m_out = m_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import ffsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_EXT = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic              op;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] seg;
    } alloc_req_t;

    typedef struct {
        logic [DATA_W-1:0] granted;
        logic [1:0]        stat;
        logic [DATA_W-1:0] largest;
    } alloc_rsp_t;

    typedef bit bool_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [DATA_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic              operation;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] block_segment;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] granted_segment;
    logic [1:0]        status;
    logic [DATA_W-1:0] largest_free;
    logic              in_taken;

    first_fit_segment_allocator #(.MAX_EXTENTS(NUM_EXT)) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .request_size    (request_size),
        .block_segment   (block_segment),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_segment (granted_segment),
        .status          (status),
        .largest_free    (largest_free)
    );

    // predictor state
    int unsigned cur_base;
    int unsigned cur_size;
    int unsigned ext_start [NUM_EXT];
    int unsigned ext_len [NUM_EXT];
    int unsigned ext_cnt;
    int unsigned max_len;
    int unsigned heap_end;

    alloc_req_t pending_reqs[$];
    alloc_rsp_t expected_rsps[$];
    int         mismatches;
    int         idle_cycles;
    int         send_idle_pct;
    int         recv_idle_pct;
    int unsigned live_segs[$];
    int unsigned live_sizes[$];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void rebuild_table();
        int unsigned last;
        for (int i = 0; i < NUM_EXT; i++)
        begin
            ext_start[i] = 0;
            ext_len[i] = 0;
        end
        ext_cnt = 0;
        max_len = 0;
        if (cur_size < 2)
        begin
            heap_end = cur_base;
            return;
        end
        last = cur_base + cur_size - 1;
        if (last > 16'hFFFF)
            last = 16'hFFFF;
        heap_end = last;
        if (last > cur_base)
        begin
            ext_start[0] = cur_base;
            ext_len[0] = last - cur_base;
            ext_cnt = 1;
            max_len = ext_len[0];
        end
    endfunction

    function automatic void drop_extent(int unsigned j);
        for (int unsigned i = j; i + 1 < ext_cnt; i++)
        begin
            ext_start[i] = ext_start[i + 1];
            ext_len[i] = ext_len[i + 1];
        end
        if (ext_cnt > 0)
        begin
            ext_cnt--;
            ext_start[ext_cnt] = 0;
            ext_len[ext_cnt] = 0;
        end
    endfunction

    function automatic alloc_rsp_t predict_allocation(alloc_req_t r);
        alloc_rsp_t  p;
        int unsigned j;
        int unsigned sz;
        int unsigned sg;
        int unsigned succ;
        int unsigned res_len;
        bool_t       nm;
        bool_t       pm;
        sz = r.size;
        sg = r.seg;
        p.granted = SEG_NONE;
        p.stat = STATUS_OK;
        if (r.op == OP_ALLOC)
        begin
            if (sz == 0 || sz > max_len)
                p.stat = STATUS_NO_FIT;
            else
            begin
                for (j = 0; j < ext_cnt; j++)
                    if (ext_len[j] >= sz)
                        break;
                if (j >= ext_cnt)
                    p.stat = STATUS_NO_FIT;
                else
                begin
                    p.granted = ext_start[j];
                    if (ext_len[j] > sz)
                    begin
                        ext_start[j] = (ext_start[j] + sz) & 16'hFFFF;
                        ext_len[j] -= sz;
                    end
                    else
                        drop_extent(j);
                    max_len = 0;
                    for (int i = 0; i < ext_cnt; i++)
                        if (ext_len[i] > max_len)
                            max_len = ext_len[i];
                end
            end
        end
        else
        begin
            for (j = 0; j < ext_cnt; j++)
                if (ext_start[j] >= sg)
                    break;
            succ = (j < ext_cnt) ? ext_start[j] : heap_end;
            if (sg + sz > succ)
                p.stat = STATUS_OVERLAP;
            else
            begin
                nm = bool_t'((j < ext_cnt) && (sg + sz == ext_start[j]));
                pm = bool_t'((j > 0) && (ext_start[j - 1] + ext_len[j - 1] == sg));
                if (nm && pm)
                begin
                    ext_len[j - 1] += sz + ext_len[j];
                    res_len = ext_len[j - 1];
                    drop_extent(j);
                end
                else if (nm)
                begin
                    ext_start[j] = sg;
                    ext_len[j] += sz;
                    res_len = ext_len[j];
                end
                else if (pm)
                begin
                    ext_len[j - 1] += sz;
                    res_len = ext_len[j - 1];
                end
                else if (ext_cnt >= NUM_EXT)
                    p.stat = STATUS_FULL;
                else
                begin
                    for (int unsigned i = ext_cnt; i > j; i--)
                    begin
                        ext_start[i] = ext_start[i - 1];
                        ext_len[i] = ext_len[i - 1];
                    end
                    ext_start[j] = sg;
                    ext_len[j] = sz;
                    ext_cnt++;
                    res_len = sz;
                end
                if (p.stat == STATUS_OK && res_len > max_len)
                    max_len = res_len & 16'hFFFF;
            end
        end
        p.largest = max_len[DATA_W-1:0];
        return p;
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= OP_ALLOC;
            request_size <= '0;
            block_segment <= '0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!in_valid || in_taken)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    operation <= pending_reqs[0].op;
                    request_size <= pending_reqs[0].size;
                    block_segment <= pending_reqs[0].seg;
                    void'(pending_reqs.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        alloc_req_t r;
        alloc_rsp_t e;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                r.op = operation;
                r.size = request_size;
                r.seg = block_segment;
                expected_rsps.push_back(predict_allocation(r));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result item");
                    mismatches++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (granted_segment !== e.granted)
                    begin
                        $error("granted_segment exp %0d got %0d", e.granted, granted_segment);
                        mismatches++;
                    end
                    if (status !== e.stat)
                    begin
                        $error("status exp %0d got %0d", e.stat, status);
                        mismatches++;
                    end
                    if (largest_free !== e.largest)
                    begin
                        $error("largest_free exp %0d got %0d", e.largest, largest_free);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
        else
            in_taken <= 1'b0;
    end

    task automatic push_item(logic op, int unsigned sz, int unsigned sg);
        alloc_req_t r;
        r.op = op;
        r.size = sz[DATA_W-1:0];
        r.seg = sg[DATA_W-1:0];
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
        repeat (4 + NUM_EXT + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HEAP_BASE)
            cur_base = val & 16'hFFFF;
        else
            cur_size = val & 16'hFFFF;
        rebuild_table();
        live_segs.delete();
        live_sizes.delete();
    endtask

    // mostly well-formed alloc/free traffic on the tracked live blocks
    task automatic random_phase(int n);
        int unsigned k;
        int unsigned sz;
        int unsigned sg;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 45)
            begin
                sz = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF)
                                               : $urandom_range(1, 40);
                push_item(OP_ALLOC, sz, $urandom_range(16'hFFFF));
            end
            else if (k < 85 && live_segs.size() > 0)
            begin
                sg = $urandom_range(live_segs.size() - 1);
                push_item(OP_FREE, live_sizes[sg], live_segs[sg]);
                live_segs.delete(sg);
                live_sizes.delete(sg);
            end
            else
                push_item(OP_FREE, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
            track_last();
        end
    endtask

    // mirror a shadow predictor to learn what the pushed alloc got
    int unsigned sh_start [NUM_EXT];
    int unsigned sh_len [NUM_EXT];
    int unsigned sh_cnt;
    int unsigned sh_max;

    task automatic track_last();
        alloc_req_t  r;
        alloc_rsp_t  p;
        int unsigned s0 [NUM_EXT];
        int unsigned l0 [NUM_EXT];
        int unsigned c0;
        int unsigned m0;
        r = pending_reqs[pending_reqs.size() - 1];
        s0 = ext_start;
        l0 = ext_len;
        c0 = ext_cnt;
        m0 = max_len;
        ext_start = sh_start;
        ext_len = sh_len;
        ext_cnt = sh_cnt;
        max_len = sh_max;
        p = predict_allocation(r);
        sh_start = ext_start;
        sh_len = ext_len;
        sh_cnt = ext_cnt;
        sh_max = max_len;
        ext_start = s0;
        ext_len = l0;
        ext_cnt = c0;
        max_len = m0;
        if (r.op == OP_ALLOC && p.stat == STATUS_OK)
        begin
            live_segs.push_back(p.granted);
            live_sizes.push_back(r.size);
        end
    endtask

    task automatic sync_shadow();
        sh_start = ext_start;
        sh_len = ext_len;
        sh_cnt = ext_cnt;
        sh_max = max_len;
    endtask

    initial
    begin
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 23;
        recv_idle_pct = 59;
        cfg_we = 1'b0;
        cfg_index = REG_HEAP_BASE;
        cfg_wdata = '0;
        cur_base = 4096;
        cur_size = 32768;
        rebuild_table();
        sync_shadow();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero size, oversize, exact fit, merges, overlap, zero-size free
        push_item(OP_ALLOC, 0, 0);
        push_item(OP_ALLOC, 16'hFFFF, 16'hFFFF);
        push_item(OP_ALLOC, 16, 0);
        push_item(OP_ALLOC, 32, 0);
        push_item(OP_ALLOC, 8, 0);
        push_item(OP_FREE, 32, 4096 + 16);
        push_item(OP_FREE, 16, 4096);
        push_item(OP_FREE, 8, 4096 + 48);
        push_item(OP_FREE, 4, 0);
        push_item(OP_FREE, 0, 100);
        push_item(OP_FREE, 16'hFFFF, 16'hFFFF);
        push_item(OP_FREE, 1, 36862);
        push_item(OP_ALLOC, 32767, 0);
        push_item(OP_ALLOC, 1, 0);
        for (int i = 0; i < 10; i++)
            push_item(OP_FREE, 1, 2 * i);
        sync_shadow();
        drain();
        for (int i = 0; i < 30; i++)
            track_dummy();
        // exact fit of whole region, then full-table frees
        write_reg(REG_HEAP_SIZE, 2);
        push_item(OP_ALLOC, 1, 0);
        push_item(OP_ALLOC, 1, 0);
        push_item(OP_FREE, 1, 0);
        sync_shadow();
        drain();
        write_reg(REG_HEAP_BASE, 16'hFFFF);
        push_item(OP_ALLOC, 1, 0);
        push_item(OP_FREE, 0, 16'hFFFF);
        sync_shadow();
        drain();
        write_reg(REG_HEAP_SIZE, 0);
        write_reg(REG_HEAP_BASE, 0);
        push_item(OP_ALLOC, 1, 0);
        push_item(OP_FREE, 0, 0);
        sync_shadow();
        drain();
        write_reg(REG_HEAP_SIZE, 16'hFFFF);
        for (int i = 0; i < 20; i++)
            push_item(OP_FREE, 1, 100 + 3 * i);
        sync_shadow();
        drain();
        // wrapped region clipped at segment space end
        write_reg(REG_HEAP_BASE, 16'hF000);
        write_reg(REG_HEAP_SIZE, 16'hFFFF);
        sync_shadow();
        random_phase(350);
        drain();

        send_idle_pct = 59;
        recv_idle_pct = 23;
        write_reg(REG_HEAP_BASE, 4096);
        write_reg(REG_HEAP_SIZE, 600);
        sync_shadow();
        random_phase(350);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_HEAP_BASE, 1);
        write_reg(REG_HEAP_SIZE, 120);
        sync_shadow();
        random_phase(350);
        drain();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    task automatic track_dummy();
    endtask

endmodule
